/* rtl/core/ppsc_pkg.sv */
`timescale 1ns / 1ps

package ppsc_pkg;

  // Word formats, signed fixed point
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Register widths
  localparam int RAD_BITS      = 31;
  localparam int STEP_BITS     = 17;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [RAD_BITS-1:0]  RAD_RESET  = RAD_BITS'(65536);
  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(655);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_HIT_RADIUS = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP  = CFG_IDX_BITS'(1);

  // Square root: radicand and iteration count
  localparam int SQ_BITS    = 2 * WORD_BITS;
  localparam int ROOT_BITS  = WORD_BITS;
  localparam int SQRT_STEPS = WORD_BITS;

  // Penetration product and force quotient
  localparam int PROD_BITS = RAD_BITS + STEP_BITS;
  localparam int QUO_BITS  = STEP_BITS;

  // Mixing weight 0.05 and the mixing datapath
  localparam int MIX_Q     = ((1 << FRAC_BITS) + 10) / 20;
  localparam int PV_BITS   = WORD_BITS + 1;
  localparam int KEEP_BITS = STEP_BITS + 1;
  localparam int MPR_BITS  = PV_BITS + KEEP_BITS;

  typedef logic signed [WORD_BITS-1:0] vel_t;

  // Word that rides along the pipeline next to the arithmetic
  typedef struct packed {
    logic act;
    logic neg_x;
    logic neg_y;
    vel_t v0x;
    vel_t v0y;
    vel_t v1x;
    vel_t v1y;
  } side_t;

endpackage

/* rtl/core/ppsc_pair_if.sv */
`timescale 1ns / 1ps

interface ppsc_pair_if;
  import ppsc_pkg::*;

  logic valid;
  logic ready;
  vel_t first_pos_x;
  vel_t first_pos_y;
  vel_t first_vel_x;
  vel_t first_vel_y;
  vel_t second_pos_x;
  vel_t second_pos_y;
  vel_t second_vel_x;
  vel_t second_vel_y;
  logic same_particle;

  modport src (
    output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
    output second_pos_x, second_pos_y, second_vel_x, second_vel_y, same_particle,
    input  ready
  );
  modport snk (
    input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
    input  second_pos_x, second_pos_y, second_vel_x, second_vel_y, same_particle,
    output ready
  );
endinterface

/* rtl/core/ppsc_vel_if.sv */
`timescale 1ns / 1ps

interface ppsc_vel_if;
  import ppsc_pkg::*;

  logic valid;
  logic ready;
  vel_t new_first_vel_x;
  vel_t new_first_vel_y;
  vel_t new_second_vel_x;
  vel_t new_second_vel_y;
  logic contact;

  modport src (
    output valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
    output new_second_vel_y, contact,
    input  ready
  );
  modport snk (
    input  valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
    input  new_second_vel_y, contact,
    output ready
  );
endinterface

/* rtl/core/ppsc_cfg_if.sv */
`timescale 1ns / 1ps

interface ppsc_cfg_if;
  import ppsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport src (output valid, index, data, input ready);
  modport snk (input valid, index, data, output ready);
endinterface

/* rtl/core/ppsc_sqrt.sv */
`timescale 1ns / 1ps

// Pipelined floor square root, one result bit per stage
module ppsc_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [ppsc_pkg::SQ_BITS-1:0]  rad_i,
  input  ppsc_pkg::side_t               side_i,
  output logic                          vld_o,
  output logic [ppsc_pkg::ROOT_BITS-1:0] root_o,
  output ppsc_pkg::side_t               side_o
);
  import ppsc_pkg::*;

  logic [SQRT_STEPS-1:0] vld_q;
  logic [SQ_BITS-1:0]    rem_q  [SQRT_STEPS];
  logic [SQ_BITS-1:0]    root_q [SQRT_STEPS];
  side_t                 side_q [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [SQ_BITS-1:0] StepBit = {{(SQ_BITS-1){1'b0}}, 1'b1} << (SQ_BITS-2-2*i);

    logic               vld_in;
    logic [SQ_BITS-1:0] rem_in, root_in, trial, rem_d, root_d;
    side_t              side_in;

    if (i == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    // trial subtract of root + bit
    assign trial = root_in + StepBit;
    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + StepBit;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
        side_q[i] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[SQRT_STEPS-1];
  assign root_o = root_q[SQRT_STEPS-1][ROOT_BITS-1:0];
  assign side_o = side_q[SQRT_STEPS-1];

endmodule

/* rtl/core/ppsc_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The numerator is below den << QUO_BITS, so the quotient fits.
module ppsc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic [ppsc_pkg::PROD_BITS-1:0] num_i,
  input  logic [ppsc_pkg::RAD_BITS-1:0]  den_i,
  input  ppsc_pkg::side_t                side_i,
  output logic                           vld_o,
  output logic [ppsc_pkg::QUO_BITS-1:0]  quo_o,
  output ppsc_pkg::side_t                side_o
);
  import ppsc_pkg::*;

  logic [QUO_BITS-1:0]  vld_q;
  logic [PROD_BITS-1:0] rem_q [QUO_BITS];
  logic [QUO_BITS-1:0]  quo_q [QUO_BITS];
  side_t                side_q [QUO_BITS];

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
    localparam int QBit = QUO_BITS - 1 - i;

    logic                 vld_in;
    logic [PROD_BITS-1:0] rem_in, dsh, rem_d;
    logic [QUO_BITS-1:0]  quo_in, quo_d;
    side_t                side_in;

    if (i == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign dsh = PROD_BITS'(den_i) << QBit;

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= dsh) begin
        rem_d       = rem_in - dsh;
        quo_d[QBit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        quo_q[i]  <= quo_d;
        side_q[i] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QUO_BITS-1];
  assign quo_o  = quo_q[QUO_BITS-1];
  assign side_o = side_q[QUO_BITS-1];

endmodule

/* rtl/core/particle_pair_soft_collision.sv */
`timescale 1ns / 1ps

// Channel  Dir  Modport  Word
// cfg_i    in   snk      register index, write data (always ready)
// pair_i   in   snk      positions, velocities, same_particle of one pair
// vel_o    out  src      four new velocities, contact
//
// One pair enters per cycle while no word waits in the skid register.
// The pipeline holds the 32-stage square root and the 17-stage force divider.
// rst_ni clears the valid bits and loads hit_radius = 1.0, time_step = 655.
// A stalled output parks one word in a skid register; the pipeline then
// freezes and pair_i.ready drops until the skid register drains.
module particle_pair_soft_collision (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppsc_cfg_if.snk     cfg_i,
  ppsc_pair_if.snk    pair_i,
  ppsc_vel_if.src     vel_o
);
  import ppsc_pkg::*;

  typedef struct packed {
    vel_t n0x;
    vel_t n0y;
    vel_t n1x;
    vel_t n1y;
    logic contact;
  } res_t;

  typedef logic signed [PV_BITS-1:0]  pv_t;
  typedef logic signed [MPR_BITS-1:0] mpr_t;

  // Rescale a mixed sum and clip it to the word range
  function automatic vel_t sat_mix(input logic signed [MPR_BITS:0] s);
    logic signed [MPR_BITS:0] sh;
    logic                     fits;
    sh   = s >>> FRAC_BITS;
    fits = (sh[MPR_BITS:WORD_BITS-1] == '0) || (sh[MPR_BITS:WORD_BITS-1] == '1);
    if (fits) begin
      return sh[WORD_BITS-1:0];
    end else if (sh[MPR_BITS]) begin
      return {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

  // Configuration registers
  logic [RAD_BITS-1:0]  rad_q;
  logic [STEP_BITS-1:0] step_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= RAD_RESET;
      step_q <= STEP_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_HIT_RADIUS: rad_q  <= cfg_i.data[RAD_BITS-1:0];
        REG_TIME_STEP:  step_q <= cfg_i.data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: frozen only while the skid register holds a word
  logic skid_vld_q, out_vld_q, en;
  assign en           = !skid_vld_q;
  assign pair_i.ready = en;

  // Stage A: offsets
  logic  vld_a_q;
  pv_t   dx_a_q, dy_a_q;
  side_t side_a_q;

  // Stage B: magnitudes, axis range check
  logic               vld_b_q;
  logic [RAD_BITS-1:0] ax_b_q, ay_b_q;
  side_t              side_b_q;

  // Stage C: squares
  logic                  vld_c_q;
  logic [2*RAD_BITS-1:0] sqx_c_q, sqy_c_q;
  side_t                 side_c_q;

  // Stage D: radicand
  logic               vld_d_q;
  logic [SQ_BITS-1:0] sum_d_q;
  side_t              side_d_q;

  // Square root outputs
  logic                 vld_s;
  logic [ROOT_BITS-1:0] dist_s;
  side_t                side_s;

  // Stage E: hit test, penetration
  logic                vld_e_q;
  logic [RAD_BITS-1:0] pen_e_q;
  side_t               side_e_q;

  // Stage F: penetration times dt
  logic                 vld_f_q;
  logic [PROD_BITS-1:0] prod_f_q;
  side_t                side_f_q;

  // Divider outputs
  logic                vld_v;
  logic [QUO_BITS-1:0] force_v;
  side_t               side_v;

  // Stage G: mixing weight, pushed velocities
  logic                 vld_g_q;
  logic [STEP_BITS-1:0] w_g_q;
  pv_t                  p0x_g_q, p0y_g_q, p1x_g_q, p1y_g_q;
  side_t                side_g_q;

  // Stage H: mixing products
  logic  vld_h_q;
  mpr_t  k0x_h_q, k0y_h_q, k1x_h_q, k1y_h_q;
  mpr_t  w0x_h_q, w0y_h_q, w1x_h_q, w1y_h_q;
  side_t side_h_q;

  // Stage A comb
  side_t side_a_d;
  always_comb begin
    side_a_d.act   = !pair_i.same_particle && (rad_q != '0);
    side_a_d.neg_x = 1'b0;
    side_a_d.neg_y = 1'b0;
    side_a_d.v0x   = pair_i.first_vel_x;
    side_a_d.v0y   = pair_i.first_vel_y;
    side_a_d.v1x   = pair_i.second_vel_x;
    side_a_d.v1y   = pair_i.second_vel_y;
  end

  // Stage B comb
  pv_t   ax_b, ay_b;
  side_t side_b_d;
  always_comb begin
    ax_b = dx_a_q[PV_BITS-1] ? -dx_a_q : dx_a_q;
    ay_b = dy_a_q[PV_BITS-1] ? -dy_a_q : dy_a_q;
    side_b_d       = side_a_q;
    side_b_d.act   = side_a_q.act && (ax_b <= $signed(PV_BITS'(rad_q)))
                     && (ay_b <= $signed(PV_BITS'(rad_q)));
    side_b_d.neg_x = dx_a_q[PV_BITS-1];
    side_b_d.neg_y = dy_a_q[PV_BITS-1];
  end

  // Stage E comb
  side_t side_e_d;
  always_comb begin
    side_e_d     = side_s;
    side_e_d.act = side_s.act && (dist_s <= ROOT_BITS'(rad_q));
  end

  // Stage G comb: push apart by the force, sign from the offset
  pv_t                           fe, push_x, push_y;
  logic [STEP_BITS+FRAC_BITS-1:0] wprod;
  always_comb begin
    fe     = $signed(PV_BITS'(force_v));
    push_x = side_v.neg_x ? fe : -fe;
    push_y = side_v.neg_y ? fe : -fe;
    wprod  = (STEP_BITS+FRAC_BITS)'(force_v) * (STEP_BITS+FRAC_BITS)'(MIX_Q);
  end

  // Stage H comb: keep = 1.0 - w
  logic signed [KEEP_BITS-1:0] keep_h, w_h;
  always_comb begin
    w_h    = $signed(KEEP_BITS'(w_g_q));
    keep_h = $signed(KEEP_BITS'(1 << FRAC_BITS)) - w_h;
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
      vld_f_q <= 1'b0;
      vld_g_q <= 1'b0;
      vld_h_q <= 1'b0;
    end else if (en) begin
      vld_a_q <= pair_i.valid;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
      vld_e_q <= vld_s;
      vld_f_q <= vld_e_q;
      vld_g_q <= vld_v;
      vld_h_q <= vld_g_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_a_q   <= $signed(PV_BITS'(pair_i.second_pos_x)) - $signed(PV_BITS'(pair_i.first_pos_x));
      dy_a_q   <= $signed(PV_BITS'(pair_i.second_pos_y)) - $signed(PV_BITS'(pair_i.first_pos_y));
      side_a_q <= side_a_d;

      ax_b_q   <= ax_b[RAD_BITS-1:0];
      ay_b_q   <= ay_b[RAD_BITS-1:0];
      side_b_q <= side_b_d;

      sqx_c_q  <= ax_b_q * ax_b_q;
      sqy_c_q  <= ay_b_q * ay_b_q;
      side_c_q <= side_b_q;

      sum_d_q  <= SQ_BITS'(sqx_c_q) + SQ_BITS'(sqy_c_q);
      side_d_q <= side_c_q;

      pen_e_q  <= rad_q - dist_s[RAD_BITS-1:0];
      side_e_q <= side_e_d;

      prod_f_q <= PROD_BITS'(pen_e_q) * PROD_BITS'(step_q);
      side_f_q <= side_e_q;

      w_g_q    <= wprod[STEP_BITS+FRAC_BITS-1:FRAC_BITS];
      p0x_g_q  <= $signed(PV_BITS'(side_v.v0x)) + push_x;
      p1x_g_q  <= $signed(PV_BITS'(side_v.v1x)) - push_x;
      p0y_g_q  <= $signed(PV_BITS'(side_v.v0y)) + push_y;
      p1y_g_q  <= $signed(PV_BITS'(side_v.v1y)) - push_y;
      side_g_q <= side_v;

      k0x_h_q  <= p0x_g_q * keep_h;
      k1x_h_q  <= p1x_g_q * keep_h;
      k0y_h_q  <= p0y_g_q * keep_h;
      k1y_h_q  <= p1y_g_q * keep_h;
      w0x_h_q  <= p0x_g_q * w_h;
      w1x_h_q  <= p1x_g_q * w_h;
      w0y_h_q  <= p0y_g_q * w_h;
      w1y_h_q  <= p1y_g_q * w_h;
      side_h_q <= side_g_q;
    end
  end

  ppsc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_d_q),
    .rad_i  (sum_d_q),
    .side_i (side_d_q),
    .vld_o  (vld_s),
    .root_o (dist_s),
    .side_o (side_s)
  );

  ppsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_f_q),
    .num_i  (prod_f_q),
    .den_i  (rad_q),
    .side_i (side_f_q),
    .vld_o  (vld_v),
    .quo_o  (force_v),
    .side_o (side_v)
  );

  // Final sums, rescale, clip; a miss passes the velocities through
  res_t res;
  always_comb begin
    res.contact = side_h_q.act;
    if (side_h_q.act) begin
      res.n0x = sat_mix($signed({k0x_h_q[MPR_BITS-1], k0x_h_q}) + $signed({w1x_h_q[MPR_BITS-1], w1x_h_q}));
      res.n1x = sat_mix($signed({k1x_h_q[MPR_BITS-1], k1x_h_q}) + $signed({w0x_h_q[MPR_BITS-1], w0x_h_q}));
      res.n0y = sat_mix($signed({k0y_h_q[MPR_BITS-1], k0y_h_q}) + $signed({w1y_h_q[MPR_BITS-1], w1y_h_q}));
      res.n1y = sat_mix($signed({k1y_h_q[MPR_BITS-1], k1y_h_q}) + $signed({w0y_h_q[MPR_BITS-1], w0y_h_q}));
    end else begin
      res.n0x = side_h_q.v0x;
      res.n0y = side_h_q.v0y;
      res.n1x = side_h_q.v1x;
      res.n1y = side_h_q.v1y;
    end
  end

  // Output register with skid stage
  res_t out_q, skid_q;
  logic take;
  assign take = !out_vld_q || vel_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
        out_vld_q  <= 1'b1;
      end
    end else if (vld_h_q) begin
      if (take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (vel_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (vld_h_q) begin
      if (take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign vel_o.valid            = out_vld_q;
  assign vel_o.new_first_vel_x  = out_q.n0x;
  assign vel_o.new_first_vel_y  = out_q.n0y;
  assign vel_o.new_second_vel_x = out_q.n1x;
  assign vel_o.new_second_vel_y = out_q.n1y;
  assign vel_o.contact          = out_q.contact;

  // Skid register only ever backs a held output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word without output word");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !vel_o.ready))
    else $error("skid filled while output was free");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_vld_q) |-> $past(vel_o.ready))
    else $error("skid drained without output handshake");

endmodule

/* tb/tb_ifs.sv */
`timescale 1ns / 1ps

// Interfaces come from the RTL tree; this file only adds the word types the bench uses.
package tb_ppsc_pkg;
  import ppsc_pkg::*;

  typedef struct {
    vel_t p0x, p0y, v0x, v0y, p1x, p1y, v1x, v1y;
    logic same;
  } pair_word_t;

  typedef struct {
    vel_t n0x, n0y, n1x, n1y;
    logic contact;
  } vel_word_t;
endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ppsc_pkg::*;
  import tb_ppsc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppsc_cfg_if  cfg_if ();
  ppsc_pair_if pair_if ();
  ppsc_vel_if  vel_if ();

  particle_pair_soft_collision i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if.snk),
    .pair_i(pair_if.snk),
    .vel_o (vel_if.src)
  );

  always #4 clk_i = ~clk_i;

  // Model copy of the registers
  logic [RAD_BITS-1:0]  radius_q = RAD_RESET;
  logic [STEP_BITS-1:0] step_q   = STEP_RESET;

  pair_word_t pending_pairs[$];
  vel_word_t  expected_vels[$];
  int         n_errors = 0;
  int         n_sent = 0;
  int         n_queued = 0;
  bit         hold_sender = 1'b0;
  bit         long_stall = 1'b0;
  bit         in_taken = 1'b0;

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic vel_t clamp_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return vel_t'(v);
  endfunction

  // Collision response of one pair
  function automatic vel_word_t collide(pair_word_t p);
    vel_word_t r;
    longint a0x, a0y, a1x, a1y, dx, dy, ax, ay, force_q, w, keep;
    longint m0x, m0y, m1x, m1y;
    longint unsigned dist_v, rad;
    a0x = p.v0x; a0y = p.v0y; a1x = p.v1x; a1y = p.v1y;
    rad = radius_q;
    r.contact = 1'b0;
    if (!p.same && rad != 0) begin
      dx = longint'(p.p1x) - longint'(p.p0x);
      dy = longint'(p.p1y) - longint'(p.p0y);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax <= rad && ay <= rad) begin
        dist_v = root_floor(ax * ax + ay * ay);
        if (dist_v <= rad) begin
          force_q = ((rad - dist_v) * step_q) / rad;
          r.contact = 1'b1;
          if (dx < 0) begin a0x += force_q; a1x -= force_q; end
          else begin a0x -= force_q; a1x += force_q; end
          if (dy < 0) begin a0y += force_q; a1y -= force_q; end
          else begin a0y -= force_q; a1y += force_q; end
          w = (force_q * MIX_Q) >>> FRAC_BITS;
          keep = (64'sd1 << FRAC_BITS) - w;
          m0x = (a0x * keep + w * a1x) >>> FRAC_BITS;
          m1x = (a1x * keep + w * a0x) >>> FRAC_BITS;
          m0y = (a0y * keep + w * a1y) >>> FRAC_BITS;
          m1y = (a1y * keep + w * a0y) >>> FRAC_BITS;
          a0x = m0x; a1x = m1x; a0y = m0y; a1y = m1y;
        end
      end
    end
    r.n0x = clamp_word(a0x);
    r.n0y = clamp_word(a0y);
    r.n1x = clamp_word(a1x);
    r.n1y = clamp_word(a1y);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    n_errors++;
  endtask

  // Driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  initial begin
    pair_if.valid = 1'b0;
    pair_if.same_particle = 1'b0;
    {pair_if.first_pos_x, pair_if.first_pos_y, pair_if.first_vel_x, pair_if.first_vel_y} = '0;
    {pair_if.second_pos_x, pair_if.second_pos_y, pair_if.second_vel_x,
     pair_if.second_vel_y} = '0;
    vel_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_HIT_RADIUS;
    cfg_if.data = '0;
  end

  // Input handshake as seen at the rising edge
  always @(posedge clk_i) begin
    in_taken <= pair_if.valid && pair_if.ready;
  end

  always @(negedge clk_i) begin
    pair_word_t p;
    if (rst_ni && !(pair_if.valid && !in_taken)) begin
      if (in_taken) n_sent++;
      if (burst_left == 0 && gap_left > 0) gap_left--;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (pending_pairs.size() > 0 && !hold_sender && (burst_left > 0 || gap_left == 0)) begin
        if (burst_left > 0) burst_left--;
        p = pending_pairs.pop_front();
        expected_vels.push_back(collide(p));
        pair_if.first_pos_x  <= p.p0x;
        pair_if.first_pos_y  <= p.p0y;
        pair_if.first_vel_x  <= p.v0x;
        pair_if.first_vel_y  <= p.v0y;
        pair_if.second_pos_x <= p.p1x;
        pair_if.second_pos_y <= p.p1y;
        pair_if.second_vel_x <= p.v1x;
        pair_if.second_vel_y <= p.v1y;
        pair_if.same_particle <= p.same;
        pair_if.valid <= 1'b1;
      end else begin
        pair_if.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern; a long hold-off is counted here
  int stall_phase = 0;
  int stall_left = 0;
  always @(negedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 97;
    if (stall_left > 0) begin
      stall_left--;
      vel_if.ready <= 1'b0;
      if (stall_left == 0) long_stall = 1'b0;
    end else if (long_stall) begin
      stall_left = 300;
      vel_if.ready <= 1'b0;
    end else if (stall_phase < 30) vel_if.ready <= 1'b1;
    else vel_if.ready <= ($urandom_range(0, 2) != 0);
  end

  // Monitor
  always @(posedge clk_i) begin
    vel_word_t e;
    if (rst_ni && vel_if.valid && vel_if.ready) begin
      if (expected_vels.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        e = expected_vels.pop_front();
        if (vel_if.new_first_vel_x !== e.n0x)
          report_mismatch("new_first_vel_x", vel_if.new_first_vel_x, e.n0x);
        if (vel_if.new_first_vel_y !== e.n0y)
          report_mismatch("new_first_vel_y", vel_if.new_first_vel_y, e.n0y);
        if (vel_if.new_second_vel_x !== e.n1x)
          report_mismatch("new_second_vel_x", vel_if.new_second_vel_x, e.n1x);
        if (vel_if.new_second_vel_y !== e.n1y)
          report_mismatch("new_second_vel_y", vel_if.new_second_vel_y, e.n1y);
        if (vel_if.contact !== e.contact)
          report_mismatch("contact", vel_if.contact, e.contact);
      end
    end
  end

  task automatic add_pair(vel_t p0x, p0y, v0x, v0y, p1x, p1y, v1x, v1y, logic same);
    pair_word_t p;
    p.p0x = p0x; p.p0y = p0y; p.v0x = v0x; p.v0y = v0y;
    p.p1x = p1x; p.p1y = p1y; p.v1x = v1x; p.v1y = v1y; p.same = same;
    pending_pairs.push_back(p);
    n_queued++;
  endtask

  function automatic vel_t rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return vel_t'($urandom_range(0, 8 << 16)) - (4 << 16);
      default: return vel_t'($urandom());
    endcase
  endfunction

  // Random near pair: offsets mostly within the current radius
  task automatic add_near_pair();
    vel_t p0x, p0y;
    int unsigned span;
    span = (radius_q > 32'h3FFFFFFF) ? 32'h7FFFFFFF : radius_q * 2 + 1;
    p0x = vel_t'($urandom()) >>> $urandom_range(0, 8);
    p0y = vel_t'($urandom()) >>> $urandom_range(0, 8);
    add_pair(p0x, p0y, rnd_word(), rnd_word(),
             vel_t'(longint'(p0x) + longint'($urandom_range(0, span)) - longint'(span / 2)),
             vel_t'(longint'(p0y) + longint'($urandom_range(0, span)) - longint'(span / 2)),
             rnd_word(), rnd_word(), $urandom_range(0, 15) == 0);
  endtask

  task automatic wait_drained();
    while (n_sent < n_queued || expected_vels.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == REG_HIT_RADIUS) radius_q = val[RAD_BITS-1:0];
    else step_q = val[STEP_BITS-1:0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [RAD_BITS-1:0]  radii[5];
    logic [STEP_BITS-1:0] steps[5];
    radii = '{RAD_BITS'(1), RAD_BITS'(65536), RAD_BITS'(32'h7FFFFFFF), RAD_BITS'(300000),
              RAD_BITS'(0)};
    steps = '{STEP_BITS'(65536), STEP_BITS'(0), STEP_BITS'(131071), STEP_BITS'(655),
              STEP_BITS'(20000)};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: same particle, touching, miss, exact radius, extremes
    add_pair(0, 0, 100, -100, 0, 0, 5, 5, 1'b1);
    add_pair(0, 0, 100, -100, 0, 0, 5, 5, 1'b0);
    add_pair(0, 0, 0, 0, 32'sd65536, 0, 0, 0, 1'b0);
    add_pair(0, 0, 0, 0, 32'sd65537, 0, 0, 0, 1'b0);
    add_pair(0, 0, 0, 0, 32'sd46341, 32'sd46341, 0, 0, 1'b0);
    add_pair(10, 10, 0, 0, 0, 0, 0, 0, 1'b0);
    add_pair(0, 0, 0, 0, -32'sd1000, 32'sd2000, 0, 0, 1'b0);
    add_pair(0, 0, 32'sh7FFFFFFF, 32'sh80000000, 5, 5, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
    add_pair(0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -5, -5, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    add_pair(32'sh80000000, 32'sh80000000, -1, -1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -1, -1, 1'b0);
    add_pair(32'sh7FFFFFFF, 32'sh80000000, 7, 7, 32'sh7FFFFFFF, 32'sh80000000, 7, 7, 1'b1);
    add_pair(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1);
    wait_drained();

    // Phases over register settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_HIT_RADIUS, radii[ph]);
      write_reg(REG_TIME_STEP, steps[ph]);
      add_pair(0, 0, 3, 3, 0, 0, -3, -3, 1'b0);
      add_pair(0, 0, 32'sh7FFFFFFF, 32'sh80000000, 1, -1, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
      for (int i = 0; i < 400; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          add_pair(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                   rnd_word(), rnd_word(), $urandom_range(0, 1));
        end else begin
          add_near_pair();
        end
      end
      if (ph == 1) begin
        // long receiver hold-off while the sender keeps offering
        while (n_sent < n_queued - 300) @(posedge clk_i);
        long_stall = 1'b1;
        while (long_stall) @(posedge clk_i);
      end
      if (ph == 2) begin
        // sender waits for every result, then resumes
        while (n_sent < n_queued - 200) @(posedge clk_i);
        hold_sender = 1'b1;
        while (expected_vels.size() != 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
